FILE: rtl/url_percent_decoder_assert.svh
// Assertion macros shared by the decoder files.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define UPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upd check failed");

// Next-cycle implication, checked out of reset
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upd check failed");

`endif

FILE: rtl/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One result beat
  typedef struct packed {
    logic       last;
    logic       has;
    logic [7:0] data;
  } res_t;

  // Decoder results for one input beat
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_res_t;

  // Hex digit value, zero for anything not a hex digit
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

  // '+' stands for a space
  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

FILE: rtl/upd_decode.sv
module upd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              take,
  output upd_pkg::dec_res_t res
);
  import upd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PCT  = 3'b010,
    ST_HELD = 3'b100
  } esc_state_t;

  esc_state_t state_r, state_nxt;
  logic [7:0] held_r, held_nxt;
  logic       ended_r, ended_nxt;

  // Escape tracking and result selection
  always_comb begin
    res       = '0;
    state_nxt = state_r;
    held_nxt  = held_r;
    ended_nxt = ended_r;
    if (ended_r) begin
      // dropping the rest of the data after an '&'
      if (last_i) ended_nxt = 1'b0;
    end else if (byte_i == CH_AMP) begin
      case (state_r)
        ST_PCT: begin
          res.cnt = 2'd1;
          res.r0  = '{last: 1'b1, has: 1'b1, data: CH_PCT};
        end
        ST_HELD: begin
          res.cnt = 2'd2;
          res.r0  = '{last: 1'b0, has: 1'b1, data: CH_PCT};
          res.r1  = '{last: 1'b1, has: 1'b1, data: plain_map(held_r)};
        end
        default: begin
          // empty field end
          res.cnt = 2'd1;
          res.r0  = '{last: 1'b1, has: 1'b0, data: 8'h00};
        end
      endcase
      state_nxt = ST_IDLE;
      held_nxt  = 8'h00;
      ended_nxt = !last_i;
    end else begin
      case (state_r)
        ST_HELD: begin
          res.cnt   = 2'd1;
          res.r0    = '{last: last_i, has: 1'b1,
                        data: {nibble_of(held_r), nibble_of(byte_i)}};
          state_nxt = ST_IDLE;
          held_nxt  = 8'h00;
        end
        ST_PCT: begin
          if (last_i) begin
            // escape cut short by the end of data
            res.cnt   = 2'd2;
            res.r0    = '{last: 1'b0, has: 1'b1, data: CH_PCT};
            res.r1    = '{last: 1'b1, has: 1'b1, data: plain_map(byte_i)};
            state_nxt = ST_IDLE;
            held_nxt  = 8'h00;
          end else begin
            held_nxt  = byte_i;
            state_nxt = ST_HELD;
          end
        end
        default: begin
          if (byte_i == CH_PCT && !last_i) begin
            state_nxt = ST_PCT;
          end else begin
            res.cnt   = 2'd1;
            res.r0    = '{last: last_i, has: 1'b1, data: plain_map(byte_i)};
            state_nxt = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= 8'h00;
      ended_r <= 1'b0;
    end else if (take) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ended_r <= ended_nxt;
    end
  end

`include "url_percent_decoder_assert.svh"
  // no escape may be open while the tail is dropped
  `UPD_ASSERT_NOW(a_ended_idle, ended_r, state_r == ST_IDLE)
  // dropped beats give nothing
  `UPD_ASSERT_NOW(a_ended_silent, ended_r, res.cnt == 2'd0)
  // a pair always starts with the raw '%' and ends the field
  `UPD_ASSERT_NOW(a_pair_shape, res.cnt == 2'd2,
                  res.r0.data == CH_PCT && !res.r0.last && res.r1.last)

endmodule

FILE: rtl/upd_obuf.sv
module upd_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::dec_res_t res,
  output logic [1:0]        free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output upd_pkg::res_t     head
);
  import upd_pkg::*;

  res_t s0_r, s0_nxt, s1_r, s1_nxt;
  logic v0_r, v0_nxt, v1_r, v1_nxt;
  logic pop;

  assign pop        = v0_r && out_tready;
  assign out_tvalid = v0_r;
  assign head       = s0_r;
  assign free       = 2'd2 - {1'b0, v0_r} - {1'b0, v1_r};

  // Shift out the head, then append new results behind what remains
  always_comb begin
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (pop) begin
      s0_nxt = s1_r;
      v0_nxt = v1_r;
      v1_nxt = 1'b0;
    end
    if (push && res.cnt != 2'd0) begin
      if (!v0_nxt) begin
        s0_nxt = res.r0;
        v0_nxt = 1'b1;
        if (res.cnt == 2'd2) begin
          s1_nxt = res.r1;
          v1_nxt = 1'b1;
        end
      end else begin
        s1_nxt = res.r0;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

`include "url_percent_decoder_assert.svh"
  // slots fill from the head
  `UPD_ASSERT_NOW(a_fill_order, v1_r, v0_r)
  // a push never needs more room than is free
  `UPD_ASSERT_NOW(a_no_overflow, push, res.cnt <= free)

endmodule

FILE: rtl/url_percent_decoder.sv
// Channel  | Beat fields (low bit first)           | Handshake
// ---------+---------------------------------------+---------------------
// in_      | tdata: byte[7:0]; tlast: last         | in_tvalid/in_tready
// out_     | tdata: byte[7:0]; tuser: has_byte;    | out_tvalid/out_tready
//          | tlast: end of decoded field           |
// One input beat per cycle while the output buffer has room. The beat is
// registered in the input register, decoded from it and written into a
// two-slot output buffer whose head slot drives out_tvalid and the output.
// A beat giving two results (an escape cut short at a field end) is decoded
// only with both slots empty; in a steady stream it holds the input until
// both slots have drained, which leaves the output idle before the pair.
// Reset is synchronous, active low, and clears the escape state and buffer.
// Input ready does not depend on output ready; a stalled output fills the
// buffer and then holds the input register, which moves again once the
// buffer has registered a pop and has room for the held beat's results.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] has_byte
  output logic       out_tlast
);
  import upd_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       take;
  logic [1:0] free;
  dec_res_t   dec_res;
  res_t       head;

  // Decode only when the buffer has room for all results of the beat
  assign take      = in_vld_r && (dec_res.cnt <= free);
  assign in_tready = !in_vld_r || take;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  upd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (in_byte_r),
    .last_i (in_last_r),
    .take   (take),
    .res    (dec_res)
  );

  upd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .res        (dec_res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = head.data;
  assign out_tuser = head.has;
  assign out_tlast = head.last;

endmodule
